// ===== src/jmep_pkg.sv =====
// shared types, codes and constants of the jpeg marker extent parser
// used by every module of the block; no dependencies

package jmep_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] BYTE_00  = 8'h00;
    localparam logic [7:0] BYTE_01  = 8'h01;
    localparam logic [7:0] BYTE_FF  = 8'hFF;
    localparam logic [7:0] BYTE_SOI = 8'hD8;
    localparam logic [7:0] BYTE_EOI = 8'hD9;
    localparam logic [7:0] BYTE_SOS = 8'hDA;
    localparam logic [7:0] BYTE_SOF0 = 8'hC0;
    localparam logic [7:0] BYTE_SOF1 = 8'hC1;
    localparam logic [7:0] BYTE_RST0 = 8'hD0;
    localparam logic [7:0] BYTE_RST7 = 8'hD7;

    localparam logic [31:0] POS_MAX = 32'hFFFF_FFFF;

    // extent walker states
    localparam logic [3:0] EX_IDLE  = 4'd0;
    localparam logic [3:0] EX_HDR1  = 4'd1;
    localparam logic [3:0] EX_SCAN  = 4'd2;
    localparam logic [3:0] EX_FF    = 4'd3;
    localparam logic [3:0] EX_LHI   = 4'd4;
    localparam logic [3:0] EX_LLO   = 4'd5;
    localparam logic [3:0] EX_SKIP  = 4'd6;
    localparam logic [3:0] EX_SLHI  = 4'd7;
    localparam logic [3:0] EX_SLLO  = 4'd8;
    localparam logic [3:0] EX_SSKIP = 4'd9;
    localparam logic [3:0] EX_ECS   = 4'd10;
    localparam logic [3:0] EX_ECSFF = 4'd11;

    // geometry walker states
    localparam logic [3:0] GM_IDLE  = 4'd0;
    localparam logic [3:0] GM_HDR1  = 4'd1;
    localparam logic [3:0] GM_SCAN  = 4'd2;
    localparam logic [3:0] GM_FF    = 4'd3;
    localparam logic [3:0] GM_LHI   = 4'd4;
    localparam logic [3:0] GM_LLO   = 4'd5;
    localparam logic [3:0] GM_SKIP  = 4'd6;
    localparam logic [3:0] GM_SOFHI = 4'd7;
    localparam logic [3:0] GM_SOFLO = 4'd8;
    localparam logic [3:0] GM_SOFP  = 4'd9;
    localparam logic [3:0] GM_H1    = 4'd10;
    localparam logic [3:0] GM_H2    = 4'd11;
    localparam logic [3:0] GM_W1    = 4'd12;
    localparam logic [3:0] GM_W2    = 4'd13;
    localparam logic [3:0] GM_DONE  = 4'd14;

    // geometry verdict
    localparam logic [1:0] GR_PENDING = 2'd0;
    localparam logic [1:0] GR_OK      = 2'd1;
    localparam logic [1:0] GR_FAIL    = 2'd2;

    // extent step outcome
    localparam logic [1:0] EXR_MORE = 2'd0;
    localparam logic [1:0] EXR_EOI  = 2'd1;
    localparam logic [1:0] EXR_FAIL = 2'd2;

    // report status
    localparam logic [1:0] ST_PAGE     = 2'd0;
    localparam logic [1:0] ST_NO_GEOM  = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
    } byte_beat_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] length;
        logic [15:0] width;
        logic [15:0] height;
    } rpt_beat_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       last_byte;
        logic       is_00;
        logic       is_01;
        logic       is_ff;
        logic       is_soi;
        logic       is_eoi;
        logic       is_sos;
        logic       is_sof;
        logic       is_rst;
    } byte_cls_t;

endpackage

// ===== src/jmep_front.sv =====
// front end: accepts byte beats and tags each byte with its marker class
// depends on jmep_pkg; feeds jmep_queue

module jmep_front
(
    input  logic                   byte_valid,
    input  jmep_pkg::byte_beat_t   byte_data,
    output logic                   byte_stall,
    input  logic                   q_full,
    output logic                   q_push,
    output jmep_pkg::byte_cls_t    q_item
);

    logic [7:0] b;

    assign b          = byte_data.data_byte;
    assign byte_stall = q_full;
    assign q_push     = byte_valid && !q_full;

    always_comb
    begin
        q_item.data_byte  = b;
        q_item.first_byte = byte_data.first_byte;
        q_item.last_byte  = byte_data.last_byte;
        q_item.is_00      = (b == jmep_pkg::BYTE_00);
        q_item.is_01      = (b == jmep_pkg::BYTE_01);
        q_item.is_ff      = (b == jmep_pkg::BYTE_FF);
        q_item.is_soi     = (b == jmep_pkg::BYTE_SOI);
        q_item.is_eoi     = (b == jmep_pkg::BYTE_EOI);
        q_item.is_sos     = (b == jmep_pkg::BYTE_SOS);
        q_item.is_sof     = (b == jmep_pkg::BYTE_SOF0) || (b == jmep_pkg::BYTE_SOF1);
        q_item.is_rst     = (b >= jmep_pkg::BYTE_RST0) && (b <= jmep_pkg::BYTE_RST7);
    end

endmodule

// ===== src/jmep_queue.sv =====
// short queue of classified bytes between front and back
// depends on jmep_pkg; DEPTH of at least 2

module jmep_queue
#(
    parameter int DEPTH = jmep_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  jmep_pkg::byte_cls_t  push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 valid,
    output jmep_pkg::byte_cls_t  item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    jmep_pkg::byte_cls_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign full   = (count_reg == CNT_W'(DEPTH));
    assign valid  = (count_reg != '0);
    assign item   = slot_reg[rd_ptr_reg];
    assign do_pop = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== src/jmep_back.sv =====
// back end: extent and geometry walkers plus the report register
// depends on jmep_pkg; drains jmep_queue

module jmep_back
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    input  jmep_pkg::byte_cls_t  q_item,
    output logic                 q_pop,
    output logic                 rpt_valid,
    output jmep_pkg::rpt_beat_t  rpt_data,
    input  logic                 rpt_stall
);

    logic        busy_reg, busy_next;
    logic [3:0]  ex_mode_reg, ex_mode_next;
    logic [31:0] pos_reg, pos_next;
    logic [15:0] ex_rem_reg, ex_rem_next;
    logic [3:0]  gm_mode_reg, gm_mode_next;
    logic [15:0] gm_rem_reg, gm_rem_next;
    logic [31:0] gm_end_reg, gm_end_next;
    logic [1:0]  gm_res_reg, gm_res_next;
    logic [15:0] fw_reg, fw_next;
    logic [15:0] fh_reg, fh_next;
    logic        out_valid_reg, out_valid_next;
    jmep_pkg::rpt_beat_t out_data_reg, out_data_next;

    jmep_pkg::byte_cls_t c;
    logic [7:0]  b;
    logic        take;
    logic        emit;
    logic [1:0]  r;
    logic [15:0] ex_seg;
    logic [15:0] gm_seg;
    logic [15:0] ex_dec;
    logic [15:0] gm_dec;
    logic [33:0] sof_end;
    logic [31:0] len;
    logic        ok;

    assign c      = q_item;
    assign b      = q_item.data_byte;
    assign take   = q_valid && (!out_valid_reg || !rpt_stall);
    assign q_pop  = take;
    assign ex_seg = ex_rem_reg | {8'h00, b};
    assign gm_seg = gm_rem_reg | {8'h00, b};
    assign ex_dec = ex_rem_reg - 16'd1;
    assign gm_dec = gm_rem_reg - 16'd1;

    always_comb
    begin
        busy_next    = busy_reg;
        ex_mode_next = ex_mode_reg;
        pos_next     = pos_reg;
        ex_rem_next  = ex_rem_reg;
        gm_mode_next = gm_mode_reg;
        gm_rem_next  = gm_rem_reg;
        gm_end_next  = gm_end_reg;
        gm_res_next  = gm_res_reg;
        fw_next      = fw_reg;
        fh_next      = fh_reg;
        r            = jmep_pkg::EXR_MORE;
        emit         = 1'b0;
        sof_end      = {2'b00, pos_next} + {18'd0, gm_seg} - 34'd1;
        len          = '0;
        ok           = 1'b0;
        out_data_next = out_data_reg;

        if (c.first_byte)
        begin
            busy_next    = 1'b1;
            ex_mode_next = jmep_pkg::EX_HDR1;
            pos_next     = '0;
            ex_rem_next  = '0;
            gm_rem_next  = '0;
            gm_end_next  = '0;
            fw_next      = '0;
            fh_next      = '0;
            if (c.is_ff)
            begin
                gm_mode_next = jmep_pkg::GM_HDR1;
                gm_res_next  = jmep_pkg::GR_PENDING;
            end
            else
            begin
                gm_mode_next = jmep_pkg::GM_DONE;
                gm_res_next  = jmep_pkg::GR_FAIL;
            end
        end
        else if (busy_reg)
        begin
            pos_next = (pos_reg == jmep_pkg::POS_MAX) ? pos_reg : pos_reg + 32'd1;
            sof_end  = {2'b00, pos_next} + {18'd0, gm_seg} - 34'd1;

            // geometry walker
            case (gm_mode_reg)
                jmep_pkg::GM_HDR1:
                begin
                    if (c.is_soi)
                    begin
                        gm_mode_next = jmep_pkg::GM_SCAN;
                    end
                    else
                    begin
                        gm_mode_next = jmep_pkg::GM_DONE;
                        gm_res_next  = jmep_pkg::GR_FAIL;
                    end
                end
                jmep_pkg::GM_SCAN:
                begin
                    if (c.is_ff)
                    begin
                        gm_mode_next = jmep_pkg::GM_FF;
                    end
                end
                jmep_pkg::GM_FF:
                begin
                    if (c.is_ff)
                    begin
                        gm_mode_next = gm_mode_reg;
                    end
                    else if (c.is_soi || c.is_01 || c.is_rst)
                    begin
                        gm_mode_next = jmep_pkg::GM_SCAN;
                    end
                    else if (c.is_sos)
                    begin
                        gm_mode_next = jmep_pkg::GM_DONE;
                        gm_res_next  = jmep_pkg::GR_FAIL;
                    end
                    else if (c.is_sof)
                    begin
                        gm_mode_next = jmep_pkg::GM_SOFHI;
                    end
                    else
                    begin
                        gm_mode_next = jmep_pkg::GM_LHI;
                    end
                end
                jmep_pkg::GM_LHI:
                begin
                    gm_rem_next  = {b, 8'h00};
                    gm_mode_next = jmep_pkg::GM_LLO;
                end
                jmep_pkg::GM_LLO:
                begin
                    if (gm_seg < 16'd2)
                    begin
                        gm_mode_next = jmep_pkg::GM_DONE;
                        gm_res_next  = jmep_pkg::GR_FAIL;
                    end
                    else
                    begin
                        gm_rem_next  = gm_seg - 16'd2;
                        gm_mode_next = (gm_seg == 16'd2) ? jmep_pkg::GM_SCAN
                                                         : jmep_pkg::GM_SKIP;
                    end
                end
                jmep_pkg::GM_SKIP:
                begin
                    gm_rem_next = gm_dec;
                    if (gm_dec == 16'd0)
                    begin
                        gm_mode_next = jmep_pkg::GM_SCAN;
                    end
                end
                jmep_pkg::GM_SOFHI:
                begin
                    gm_rem_next  = {b, 8'h00};
                    gm_mode_next = jmep_pkg::GM_SOFLO;
                end
                jmep_pkg::GM_SOFLO:
                begin
                    if (gm_seg < 16'd7)
                    begin
                        gm_mode_next = jmep_pkg::GM_DONE;
                        gm_res_next  = jmep_pkg::GR_FAIL;
                    end
                    else
                    begin
                        gm_end_next  = (sof_end[33:32] != 2'b00) ? jmep_pkg::POS_MAX
                                                                 : sof_end[31:0];
                        gm_mode_next = jmep_pkg::GM_SOFP;
                    end
                end
                jmep_pkg::GM_SOFP:
                begin
                    gm_mode_next = jmep_pkg::GM_H1;
                end
                jmep_pkg::GM_H1:
                begin
                    fh_next      = {b, 8'h00};
                    gm_mode_next = jmep_pkg::GM_H2;
                end
                jmep_pkg::GM_H2:
                begin
                    fh_next      = fh_reg | {8'h00, b};
                    gm_mode_next = jmep_pkg::GM_W1;
                end
                jmep_pkg::GM_W1:
                begin
                    fw_next      = {b, 8'h00};
                    gm_mode_next = jmep_pkg::GM_W2;
                end
                jmep_pkg::GM_W2:
                begin
                    fw_next      = fw_reg | {8'h00, b};
                    gm_mode_next = jmep_pkg::GM_DONE;
                    gm_res_next  = ((fw_next != 16'd0) && (fh_reg != 16'd0))
                                   ? jmep_pkg::GR_OK : jmep_pkg::GR_FAIL;
                end
                default:
                begin
                    gm_mode_next = gm_mode_reg;
                end
            endcase

            // extent walker
            case (ex_mode_reg)
                jmep_pkg::EX_HDR1:
                begin
                    ex_mode_next = jmep_pkg::EX_SCAN;
                end
                jmep_pkg::EX_SCAN:
                begin
                    if (c.is_ff)
                    begin
                        ex_mode_next = jmep_pkg::EX_FF;
                    end
                end
                jmep_pkg::EX_FF,
                jmep_pkg::EX_ECSFF:
                begin
                    if (c.is_eoi)
                    begin
                        r = jmep_pkg::EXR_EOI;
                    end
                    else if (c.is_ff)
                    begin
                        ex_mode_next = ex_mode_reg;
                    end
                    else if (c.is_rst)
                    begin
                        ex_mode_next = (ex_mode_reg == jmep_pkg::EX_FF) ? jmep_pkg::EX_SCAN
                                                                        : jmep_pkg::EX_ECS;
                    end
                    else if (c.is_00 && (ex_mode_reg == jmep_pkg::EX_ECSFF))
                    begin
                        ex_mode_next = jmep_pkg::EX_ECS;
                    end
                    else if (c.is_01)
                    begin
                        ex_mode_next = jmep_pkg::EX_SCAN;
                    end
                    else if (c.is_sos)
                    begin
                        ex_mode_next = jmep_pkg::EX_SLHI;
                    end
                    else
                    begin
                        ex_mode_next = jmep_pkg::EX_LHI;
                    end
                end
                jmep_pkg::EX_LHI:
                begin
                    ex_rem_next  = {b, 8'h00};
                    ex_mode_next = jmep_pkg::EX_LLO;
                end
                jmep_pkg::EX_SLHI:
                begin
                    ex_rem_next  = {b, 8'h00};
                    ex_mode_next = jmep_pkg::EX_SLLO;
                end
                jmep_pkg::EX_LLO,
                jmep_pkg::EX_SLLO:
                begin
                    if (ex_seg < 16'd2)
                    begin
                        r = jmep_pkg::EXR_FAIL;
                    end
                    else
                    begin
                        ex_rem_next = ex_seg - 16'd2;
                        if (ex_mode_reg == jmep_pkg::EX_LLO)
                        begin
                            ex_mode_next = (ex_seg == 16'd2) ? jmep_pkg::EX_SCAN
                                                             : jmep_pkg::EX_SKIP;
                        end
                        else
                        begin
                            ex_mode_next = (ex_seg == 16'd2) ? jmep_pkg::EX_ECS
                                                             : jmep_pkg::EX_SSKIP;
                        end
                    end
                end
                jmep_pkg::EX_SKIP,
                jmep_pkg::EX_SSKIP:
                begin
                    ex_rem_next = ex_dec;
                    if (ex_dec == 16'd0)
                    begin
                        ex_mode_next = (ex_mode_reg == jmep_pkg::EX_SKIP) ? jmep_pkg::EX_SCAN
                                                                          : jmep_pkg::EX_ECS;
                    end
                end
                jmep_pkg::EX_ECS:
                begin
                    if (c.is_ff)
                    begin
                        ex_mode_next = jmep_pkg::EX_ECSFF;
                    end
                end
                default:
                begin
                    ex_mode_next = ex_mode_reg;
                end
            endcase
        end

        // report
        len = (pos_next == jmep_pkg::POS_MAX) ? pos_next : pos_next + 32'd1;
        ok  = (gm_res_next == jmep_pkg::GR_OK) && (len >= gm_end_reg);
        if (c.first_byte || busy_reg)
        begin
            if (r == jmep_pkg::EXR_EOI)
            begin
                emit                 = 1'b1;
                out_data_next.status = ok ? jmep_pkg::ST_PAGE : jmep_pkg::ST_NO_GEOM;
                out_data_next.length = len;
                out_data_next.width  = ok ? fw_next : 16'd0;
                out_data_next.height = ok ? fh_next : 16'd0;
            end
            else if ((r == jmep_pkg::EXR_FAIL) || c.last_byte)
            begin
                emit                 = 1'b1;
                out_data_next.status = jmep_pkg::ST_NOT_FOUND;
                out_data_next.length = '0;
                out_data_next.width  = '0;
                out_data_next.height = '0;
            end
        end
        if (emit)
        begin
            busy_next    = 1'b0;
            ex_mode_next = jmep_pkg::EX_IDLE;
            gm_mode_next = jmep_pkg::GM_IDLE;
        end

        out_valid_next = out_valid_reg && rpt_stall;
        if (take && emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            ex_mode_reg   <= jmep_pkg::EX_IDLE;
            pos_reg       <= '0;
            ex_rem_reg    <= '0;
            gm_mode_reg   <= jmep_pkg::GM_IDLE;
            gm_rem_reg    <= '0;
            gm_end_reg    <= '0;
            gm_res_reg    <= jmep_pkg::GR_PENDING;
            fw_reg        <= '0;
            fh_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                busy_reg    <= busy_next;
                ex_mode_reg <= ex_mode_next;
                pos_reg     <= pos_next;
                ex_rem_reg  <= ex_rem_next;
                gm_mode_reg <= gm_mode_next;
                gm_rem_reg  <= gm_rem_next;
                gm_end_reg  <= gm_end_next;
                gm_res_reg  <= gm_res_next;
                fw_reg      <= fw_next;
                fh_reg      <= fh_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && emit)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign rpt_valid = out_valid_reg;
    assign rpt_data  = out_data_reg;

    a_emit_needs_candidate: assert property (@(posedge clk) disable iff (!rst_n)
        take && emit |-> (busy_reg || c.first_byte))
        else $error("report without an open candidate");

    a_emit_closes: assert property (@(posedge clk) disable iff (!rst_n)
        take && emit |=> !busy_reg && (ex_mode_reg == jmep_pkg::EX_IDLE))
        else $error("candidate still open after report");

    a_busy_mode: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (ex_mode_reg != jmep_pkg::EX_IDLE) && (gm_mode_reg != jmep_pkg::GM_IDLE))
        else $error("open candidate with idle walker");

    a_page_geom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_data_reg.status == jmep_pkg::ST_PAGE)
        |-> (out_data_reg.width != 16'd0) && (out_data_reg.height != 16'd0)
            && (out_data_reg.length >= 32'd2))
        else $error("page reported with empty geometry");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_data_reg.status == jmep_pkg::ST_NOT_FOUND)
        |-> (out_data_reg.length == 32'd0))
        else $error("not-found report carries a length");

endmodule

// ===== src/jpeg_marker_extent_parser_core.sv =====
// top level of the jpeg marker extent parser: front, queue and back
// depends on jmep_pkg, jmep_front, jmep_queue and jmep_back
//
// usage
//   byte channel (byte_valid / byte_stall / byte_data): one buffer byte per
//   beat; first_byte marks the first SOI byte and opens a candidate,
//   last_byte marks the final byte of the buffer. bytes outside an open
//   candidate are dropped.
//   report channel (rpt_valid / rpt_stall / rpt_data): at most one beat per
//   candidate, carrying status, length and geometry, sent on EOI, on a bad
//   segment length or at the buffer end.
//   throughput: one byte per cycle while no report waits on rpt_stall, set by
//   the back end walkers, which take one queued byte per cycle.
//   report path: the byte that closes the candidate is first written into
//   the queue; the walkers load the report register as they take it, and
//   rpt_valid is driven from that register.
//   reset: queue empties, walkers go idle, no candidate is open.
//   receiver stall: a pending report holds in the report register and the
//   walkers take no byte while it waits; the queue of QUEUE_DEPTH bytes then
//   fills and raises byte_stall.

module jpeg_marker_extent_parser_core
#(
    parameter int QUEUE_DEPTH = jmep_pkg::QUEUE_DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_stall,
    input  jmep_pkg::byte_beat_t byte_data,
    output logic                 rpt_valid,
    input  logic                 rpt_stall,
    output jmep_pkg::rpt_beat_t  rpt_data
);

    logic                q_full;
    logic                q_push;
    jmep_pkg::byte_cls_t q_in;
    logic                q_pop;
    logic                q_valid;
    jmep_pkg::byte_cls_t q_out;

    jmep_front u_front
    (
        .byte_valid (byte_valid),
        .byte_data  (byte_data),
        .byte_stall (byte_stall),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (q_in)
    );

    jmep_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .item      (q_out)
    );

    jmep_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_out),
        .q_pop     (q_pop),
        .rpt_valid (rpt_valid),
        .rpt_data  (rpt_data),
        .rpt_stall (rpt_stall)
    );

endmodule

// ===== bench/tb.sv =====
// testbench for jpeg_marker_extent_parser_core: random jpeg byte streams against a
// built-in marker and frame header walker, checking every report beat
// depends on jmep_pkg and the parser rtl
`timescale 1ns / 100ps

module tb;
    import jmep_pkg::*;

    localparam logic [7:0] MK_APP0 = 8'hE0;
    localparam logic [7:0] MK_DHT  = 8'hC4;
    localparam logic [7:0] MK_DQT  = 8'hDB;
    localparam logic [7:0] MK_DRI  = 8'hDD;
    localparam logic [7:0] MK_COM  = 8'hFE;
    localparam logic [7:0] MK_SOF2 = 8'hC2;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       byte_valid = 1'b0;
    logic       byte_stall;
    byte_beat_t byte_data = '0;
    logic       rpt_valid;
    logic       rpt_stall = 1'b0;
    rpt_beat_t  rpt_data;

    byte_beat_t bytes_to_send [$];
    rpt_beat_t  reports_due [$];
    logic [7:0] img [$];

    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  hold_left = 0;
    bit  byte_took = 1'b0;
    int  err_count = 0;
    int  stim_items = 0;
    int  bytes_taken = 0;
    int  n_page = 0;
    int  n_nogeom = 0;
    int  n_missing = 0;
    rpt_beat_t due;

    // walker state
    logic        cand_open;
    logic [3:0]  ext_state;
    logic [3:0]  geo_state;
    logic [31:0] pos;
    logic [31:0] sof_end;
    logic [15:0] ext_left;
    logic [15:0] geo_left;
    logic [1:0]  geo_verdict;
    logic [15:0] img_w;
    logic [15:0] img_h;

    jpeg_marker_extent_parser_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .byte_valid(byte_valid),
        .byte_stall(byte_stall),
        .byte_data(byte_data),
        .rpt_valid(rpt_valid),
        .rpt_stall(rpt_stall),
        .rpt_data(rpt_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic is_rst(input logic [7:0] b);
        return b >= BYTE_RST0 && b <= BYTE_RST7;
    endfunction

    task clear_walkers;
        cand_open = 1'b0;
        ext_state = EX_IDLE;
        geo_state = GM_IDLE;
        pos = '0;
        sof_end = '0;
        ext_left = '0;
        geo_left = '0;
        geo_verdict = GR_PENDING;
        img_w = '0;
        img_h = '0;
    endtask

    task geo_fail;
        geo_state = GM_DONE;
        geo_verdict = GR_FAIL;
    endtask

    task automatic geo_step(input logic [7:0] b);
        logic [15:0] seg;
        logic [32:0] fin;
        case (geo_state)
            GM_HDR1:
                if (b == BYTE_SOI) geo_state = GM_SCAN;
                else geo_fail();
            GM_SCAN:
                if (b == BYTE_FF) geo_state = GM_FF;
            GM_FF:
                if (b == BYTE_FF) geo_state = GM_FF;
                else if (b == BYTE_SOI || b == BYTE_01 || is_rst(b)) geo_state = GM_SCAN;
                else if (b == BYTE_SOS) geo_fail();
                else if (b == BYTE_SOF0 || b == BYTE_SOF1) geo_state = GM_SOFHI;
                else geo_state = GM_LHI;
            GM_LHI:
            begin
                geo_left = {b, 8'h00};
                geo_state = GM_LLO;
            end
            GM_LLO:
            begin
                seg = {geo_left[15:8], b};
                if (seg < 16'd2) geo_fail();
                else
                begin
                    geo_left = seg - 16'd2;
                    geo_state = (geo_left != 0) ? GM_SKIP : GM_SCAN;
                end
            end
            GM_SKIP:
            begin
                geo_left = geo_left - 16'd1;
                if (geo_left == 0) geo_state = GM_SCAN;
            end
            GM_SOFHI:
            begin
                geo_left = {b, 8'h00};
                geo_state = GM_SOFLO;
            end
            GM_SOFLO:
            begin
                seg = {geo_left[15:8], b};
                if (seg < 16'd7) geo_fail();
                else
                begin
                    fin = {1'b0, pos} + {17'd0, seg} - 33'd1;
                    sof_end = fin[32] ? POS_MAX : fin[31:0];
                    geo_state = GM_SOFP;
                end
            end
            GM_SOFP: geo_state = GM_H1;
            GM_H1:
            begin
                img_h = {b, 8'h00};
                geo_state = GM_H2;
            end
            GM_H2:
            begin
                img_h[7:0] = b;
                geo_state = GM_W1;
            end
            GM_W1:
            begin
                img_w = {b, 8'h00};
                geo_state = GM_W2;
            end
            GM_W2:
            begin
                img_w[7:0] = b;
                geo_state = GM_DONE;
                geo_verdict = (img_w != 0 && img_h != 0) ? GR_OK : GR_FAIL;
            end
            default: ;
        endcase
    endtask

    // marker byte after an ff in the segment walk
    function automatic logic [1:0] ext_marker(input logic [7:0] b);
        if (b == BYTE_EOI) return EXR_EOI;
        if (b == BYTE_FF) ext_state = EX_FF;
        else if (b == BYTE_01 || is_rst(b)) ext_state = EX_SCAN;
        else if (b == BYTE_SOS) ext_state = EX_SLHI;
        else ext_state = EX_LHI;
        return EXR_MORE;
    endfunction

    function automatic logic [1:0] ext_step(input logic [7:0] b);
        logic [15:0] seg;
        logic [1:0]  r;
        r = EXR_MORE;
        case (ext_state)
            EX_HDR1: ext_state = EX_SCAN;
            EX_SCAN:
                if (b == BYTE_FF) ext_state = EX_FF;
            EX_FF: r = ext_marker(b);
            EX_LHI:
            begin
                ext_left = {b, 8'h00};
                ext_state = EX_LLO;
            end
            EX_SLHI:
            begin
                ext_left = {b, 8'h00};
                ext_state = EX_SLLO;
            end
            EX_LLO, EX_SLLO:
            begin
                seg = {ext_left[15:8], b};
                if (seg < 16'd2) r = EXR_FAIL;
                else
                begin
                    ext_left = seg - 16'd2;
                    if (ext_state == EX_LLO) ext_state = (ext_left != 0) ? EX_SKIP : EX_SCAN;
                    else ext_state = (ext_left != 0) ? EX_SSKIP : EX_ECS;
                end
            end
            EX_SKIP, EX_SSKIP:
            begin
                ext_left = ext_left - 16'd1;
                if (ext_left == 0) ext_state = (ext_state == EX_SKIP) ? EX_SCAN : EX_ECS;
            end
            EX_ECS:
                if (b == BYTE_FF) ext_state = EX_ECSFF;
            EX_ECSFF:
                if (b == BYTE_EOI) r = EXR_EOI;
                else if (b == BYTE_00 || is_rst(b)) ext_state = EX_ECS;
                else if (b != BYTE_FF) r = ext_marker(b);
            default: ;
        endcase
        return r;
    endfunction

    task automatic walk_byte(input byte_beat_t bt);
        logic [1:0]  r;
        logic [31:0] len;
        logic        ok;
        logic        live;
        rpt_beat_t   rep;
        r = EXR_MORE;
        live = cand_open;
        if (bt.first_byte)
        begin
            clear_walkers();
            live = 1'b1;
            cand_open = 1'b1;
            ext_state = EX_HDR1;
            if (bt.data_byte == BYTE_FF) geo_state = GM_HDR1;
            else geo_fail();
        end
        else if (live)
        begin
            if (pos != POS_MAX) pos = pos + 32'd1;
            geo_step(bt.data_byte);
            r = ext_step(bt.data_byte);
        end
        if (live && (r != EXR_MORE || bt.last_byte))
        begin
            rep = '0;
            if (r == EXR_EOI)
            begin
                len = (pos == POS_MAX) ? POS_MAX : pos + 32'd1;
                ok = (geo_verdict == GR_OK) && (len >= sof_end);
                rep.status = ok ? ST_PAGE : ST_NO_GEOM;
                rep.length = len;
                rep.width = ok ? img_w : 16'd0;
                rep.height = ok ? img_h : 16'd0;
            end
            else rep.status = ST_NOT_FOUND;
            reports_due.push_back(rep);
            cand_open = 1'b0;
            ext_state = EX_IDLE;
            geo_state = GM_IDLE;
        end
    endtask

    task flag_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
        err_count++;
        $display("mismatch: %s got %0h want %0h", what, got, want);
    endtask

    // monitor: predicts on accepted bytes, checks accepted reports
    always @(posedge clk)
    begin
        if (rst_n && byte_valid && !byte_stall)
        begin
            walk_byte(byte_data);
            bytes_taken++;
            byte_took = 1'b1;
        end
        if (rst_n && rpt_valid && !rpt_stall)
        begin
            if (reports_due.size() == 0)
                flag_mismatch("unexpected report, status", 32'(rpt_data.status), 32'd0);
            else
            begin
                due = reports_due.pop_front();
                if (rpt_data.status !== due.status)
                    flag_mismatch("status", 32'(rpt_data.status), 32'(due.status));
                if (rpt_data.length !== due.length)
                    flag_mismatch("length", rpt_data.length, due.length);
                if (rpt_data.width !== due.width)
                    flag_mismatch("width", 32'(rpt_data.width), 32'(due.width));
                if (rpt_data.height !== due.height)
                    flag_mismatch("height", 32'(rpt_data.height), 32'(due.height));
                case (due.status)
                    ST_PAGE: n_page++;
                    ST_NO_GEOM: n_nogeom++;
                    default: n_missing++;
                endcase
            end
        end
    end

    // byte driver
    always @(negedge clk)
    begin
        if (rst_n && (!byte_valid || byte_took))
        begin
            byte_took = 1'b0;
            if (bytes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                byte_valid <= 1'b1;
                byte_data <= bytes_to_send.pop_front();
            end
            else byte_valid <= 1'b0;
        end
    end

    // report stall driver, with a long hold-off on request
    always @(negedge clk)
    begin
        if (!rst_n) rpt_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            rpt_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else rpt_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic add_beat(input logic [7:0] b, input logic f, input logic l);
        byte_beat_t bt;
        bt.data_byte = b;
        bt.first_byte = f;
        bt.last_byte = l;
        bytes_to_send.push_back(bt);
    endtask

    task automatic push(input logic [7:0] b);
        img.push_back(b);
    endtask

    function automatic logic [7:0] any_segment_code();
        case ($urandom_range(6))
            0: return MK_DHT;
            1: return MK_DQT;
            2: return MK_DRI;
            3: return MK_COM;
            4: return MK_SOF2;
            default: return MK_APP0 | 8'($urandom_range(15));
        endcase
    endfunction

    function automatic logic [15:0] pick_dim();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'($urandom_range(65535));
            default: return 16'($urandom_range(4096, 1));
        endcase
    endfunction

    task automatic add_segment(input logic [7:0] code, input int n);
        logic [15:0] len;
        len = 16'(n + 2);
        push(BYTE_FF);
        push(code);
        push(len[15:8]);
        push(len[7:0]);
        repeat (n) push(8'($urandom_range(255)));
    endtask

    task automatic add_frame_header();
        logic [15:0] len;
        logic [15:0] h;
        logic [15:0] w;
        int i;
        case ($urandom_range(9))
            0: len = 16'd7;
            1: len = 16'($urandom_range(6, 2));
            default: len = 16'(8 + 3 * $urandom_range(3, 1));
        endcase
        h = pick_dim();
        w = pick_dim();
        push(BYTE_FF);
        push($urandom_range(1) ? BYTE_SOF1 : BYTE_SOF0);
        push(len[15:8]);
        push(len[7:0]);
        for (i = 0; i < int'(len) - 2; i++)
            case (i)
                0: push(8'd8);
                1: push(h[15:8]);
                2: push(h[7:0]);
                3: push(w[15:8]);
                4: push(w[7:0]);
                default: push(8'($urandom_range(255)));
            endcase
    endtask

    task automatic add_scan_data(input int n);
        int i;
        for (i = 0; i < n; i++)
            case ($urandom_range(9))
                0:
                begin
                    push(BYTE_FF);
                    push(BYTE_00);
                end
                1:
                begin
                    push(BYTE_FF);
                    push(BYTE_RST0 + 8'($urandom_range(7)));
                end
                2:
                begin
                    push(BYTE_FF);
                    push(BYTE_FF);
                    push(BYTE_00);
                end
                default: push(8'($urandom_range(254)));
            endcase
    endtask

    task automatic add_image();
        int  k;
        int  i;
        int  cut;
        logic have_sof;
        img.delete();
        push(BYTE_FF);
        push(BYTE_SOI);
        if ($urandom_range(30) == 0) img[0] = 8'($urandom_range(254));
        if ($urandom_range(99) < 8)
        begin
            repeat ($urandom_range(25, 2))
                push($urandom_range(3) == 0 ? BYTE_FF : 8'($urandom_range(255)));
        end
        else
        begin
            have_sof = 1'b0;
            repeat ($urandom_range(4))
                case ($urandom_range(9))
                    0: push(BYTE_FF);
                    1:
                    begin
                        push(BYTE_FF);
                        push(BYTE_01);
                    end
                    2:
                    begin
                        push(BYTE_FF);
                        push(BYTE_RST0 + 8'($urandom_range(7)));
                    end
                    3:
                    begin
                        add_frame_header();
                        have_sof = 1'b1;
                    end
                    default:
                        if ($urandom_range(79) == 0) add_segment(any_segment_code(),
                                                                 $urandom_range(300, 250));
                        else add_segment(any_segment_code(), $urandom_range(6));
                endcase
            if (!have_sof && $urandom_range(3) != 0) add_frame_header();
            if ($urandom_range(24) == 0)
            begin
                push(BYTE_FF);
                push(MK_DQT);
                push(BYTE_00);
                push(8'($urandom_range(1)));
            end
            if ($urandom_range(4) != 0)
            begin
                add_segment(BYTE_SOS, $urandom_range(8));
                add_scan_data($urandom_range(20));
                if ($urandom_range(4) == 0)
                begin
                    add_segment(MK_DHT, $urandom_range(4));
                    add_segment(BYTE_SOS, $urandom_range(4));
                    add_scan_data($urandom_range(12));
                end
            end
            push(BYTE_FF);
            push(BYTE_EOI);
        end
        // cut short with buffer end, abandon, or mark buffer end after the image
        k = $urandom_range(99);
        cut = img.size();
        if (k < 16) cut = $urandom_range(img.size(), 1);
        for (i = 0; i < cut; i++)
            add_beat(img[i], i == 0, i == cut - 1 && (k < 10 || (k >= 16 && k < 28)));
        stim_items += cut;
        if (k >= 28 && k < 40)
            repeat ($urandom_range(3, 1))
                add_beat(8'($urandom_range(255)), 1'b0, $urandom_range(3) == 0);
    endtask

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int phase;
        int goal;
        clear_walkers();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 58 : 0;
            recv_idle_pct = (phase == 0) ? 58 : (phase == 1) ? 15 : 0;
            if (phase == 2) hold_left = 400;
            if (phase == 0)
            begin
                // bare soi / eoi
                add_beat(BYTE_FF, 1'b1, 1'b0);
                add_beat(BYTE_SOI, 1'b0, 1'b0);
                add_beat(BYTE_FF, 1'b0, 1'b0);
                add_beat(BYTE_EOI, 1'b0, 1'b0);
                // one-byte candidate at buffer end
                add_beat(BYTE_FF, 1'b1, 1'b1);
                // bad segment length
                add_beat(BYTE_FF, 1'b1, 1'b0);
                add_beat(BYTE_SOI, 1'b0, 1'b0);
                add_beat(BYTE_FF, 1'b0, 1'b0);
                add_beat(MK_APP0, 1'b0, 1'b0);
                add_beat(BYTE_00, 1'b0, 1'b0);
                add_beat(BYTE_01, 1'b0, 1'b0);
                // candidate opened on a non-ff byte
                add_beat(BYTE_00, 1'b1, 1'b0);
                add_beat(BYTE_FF, 1'b0, 1'b0);
                add_beat(BYTE_EOI, 1'b0, 1'b0);
                // buffer end while that candidate is still open
                add_beat(8'h5A, 1'b0, 1'b0);
                add_beat(BYTE_00, 1'b0, 1'b1);
                // restart while busy
                add_beat(BYTE_FF, 1'b1, 1'b0);
                add_beat(BYTE_SOI, 1'b0, 1'b0);
                add_beat(BYTE_FF, 1'b1, 1'b0);
                add_beat(BYTE_SOI, 1'b0, 1'b0);
                add_beat(BYTE_FF, 1'b0, 1'b0);
                add_beat(BYTE_EOI, 1'b0, 1'b1);
            end
            goal = stim_items + 430;
            while (stim_items < goal) add_image();
            while (bytes_to_send.size() != 0 || byte_valid || reports_due.size() != 0)
                @(posedge clk);
        end
        repeat (12) @(posedge clk);
        $display("covered %0d bytes in three stall mixes and one long report hold-off", bytes_taken);
        $display("reports checked: %0d with geometry, %0d without, %0d not found",
                 n_page, n_nogeom, n_missing);
        if (err_count == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/jmep_pkg.sv
src/jmep_front.sv
src/jmep_queue.sv
src/jmep_back.sv
src/jpeg_marker_extent_parser_core.sv
bench/tb.sv
